@@ sv/swts_pkg.sv @@
// Shared constants, codes, state type and word normalize function
// for the sorted word table search block. No dependencies.
package swts_pkg;

  localparam int MAX_WORDS = 256;
  localparam int KEY_BYTES = 8;

  localparam int KEY_W   = 64;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int FIELD_W = 9;
  localparam int ADDR_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W   = $clog2(MAX_WORDS + 1);
  localparam int KEPT_W  = $clog2(KEY_BYTES + 1);

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SORT   = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_LD_RD   = 12'b000000000010,
    S_LD_CMP  = 12'b000000000100,
    S_SO_IRD  = 12'b000000001000,
    S_SO_ILAT = 12'b000000010000,
    S_SO_JRD  = 12'b000000100000,
    S_SO_JCMP = 12'b000001000000,
    S_SO_SW1  = 12'b000010000000,
    S_SO_SW2  = 12'b000100000000,
    S_SR_RD   = 12'b001000000000,
    S_SR_CMP  = 12'b010000000000,
    S_DONE    = 12'b100000000000
  } state_t;

  function automatic logic is_punct(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_DQUOTE) || (b == CH_PERIOD) ||
           (b == CH_APOS) || (b == CH_COMMA) || (b == CH_BANG) ||
           (b == CH_QMARK);
  endfunction

  // Cut at the first zero byte, optionally drop punctuation, left-align.
  function automatic logic [KEY_W-1:0] normalize(input logic [KEY_W-1:0] key,
                                                 input logic strip);
    logic [KEY_W-1:0]  acc;
    logic [KEPT_W-1:0] kept;
    logic              stop;
    logic [7:0]        b;
    acc  = '0;
    kept = '0;
    stop = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = key[(KEY_BYTES-1-i)*8 +: 8];
      if (b == 8'h00) begin
        stop = 1'b1;
      end else if (!stop && !(strip && is_punct(b))) begin
        acc[(KEY_BYTES-1-int'(kept))*8 +: 8] = b;
        kept = kept + KEPT_W'(1);
      end
    end
    return acc;
  endfunction

endpackage

@@ sv/swts_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sorted_word_table_search.sv @@
// Sorted word table search: load with dedup, selection sort, binary search.
// Depends on swts_pkg and swts_ram.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one beat: opcode and word_key.
//   in_stall is high while an operation runs; one beat is taken at a time.
//   Result channel (out_valid/out_stall) returns exactly one beat per input
//   beat: status, position and entry_count. The result sits in an output
//   register, so the next input beat is accepted while it waits.
//   All work compares 64-bit words read from the word store RAM,
//   which has one read and one write port and a registered read.
//   Per beat: load reads and compares each stored entry in turn,
//   stopping at a duplicate; sort reads and compares per inner step
//   and writes twice per swap, one swap per outer step; search reads
//   and compares once per probe; an unused opcode goes straight to done.
//   Reset (rst_n low, synchronous) empties the table; stored words are not
//   cleared and only entries below the count are read. A stalled result
//   holds the block in its done state until the beat is taken.
module sorted_word_table_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [swts_pkg::OP_W-1:0]    in_opcode,
  input  logic [swts_pkg::KEY_W-1:0]   in_word_key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [swts_pkg::STAT_W-1:0]  out_status,
  output logic [swts_pkg::FIELD_W-1:0] out_position,
  output logic [swts_pkg::FIELD_W-1:0] out_entry_count
);
  import swts_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hx_r, hx_nxt;
  logic [CNT_W-1:0]    best_r, best_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KEY_W-1:0]    ival_r, ival_nxt;
  logic [KEY_W-1:0]    bval_r, bval_nxt;
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]  out_pos_r, out_pos_nxt;
  logic [FIELD_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [KEY_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;

  logic [CNT_W:0]      mid_sum;
  logic [CNT_W-1:0]    mid;
  logic                in_take;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hx_r} - (CNT_W+1)'(1);
  assign mid     = mid_sum[CNT_W:1];
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  swts_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hx_nxt        = hx_r;
    best_nxt      = best_r;
    key_nxt       = key_r;
    ival_nxt      = ival_r;
    bval_nxt      = bval_r;
    stat_nxt      = stat_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_wdata     = key_r;
    ram_raddr     = j_r[ADDR_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          stat_nxt = ST_OK;
          pos_nxt  = '0;
          j_nxt    = '0;
          i_nxt    = '0;
          lo_nxt   = '0;
          hx_nxt   = cnt_r;
          case (in_opcode)
            OP_LOAD: begin
              key_nxt   = normalize(in_word_key, 1'b1);
              state_nxt = S_LD_RD;
            end
            OP_SORT: begin
              state_nxt = S_SO_IRD;
            end
            OP_SEARCH: begin
              key_nxt   = normalize(in_word_key, 1'b0);
              state_nxt = S_SR_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LD_RD: begin
        if (j_r == cnt_r) begin
          if (cnt_r >= CNT_W'(MAX_WORDS)) begin
            stat_nxt = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          state_nxt = S_DONE;
        end else begin
          ram_raddr = j_r[ADDR_W-1:0];
          state_nxt = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        if (ram_rdata == key_r) begin
          stat_nxt  = ST_DUP;
          state_nxt = S_DONE;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_LD_RD;
        end
      end
      S_SO_IRD: begin
        if (i_r >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_raddr = i_r[ADDR_W-1:0];
          j_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SO_ILAT;
        end
      end
      S_SO_ILAT: begin
        ival_nxt  = ram_rdata;
        bval_nxt  = ram_rdata;
        best_nxt  = i_r;
        state_nxt = S_SO_JRD;
      end
      S_SO_JRD: begin
        if (j_r >= cnt_r) begin
          state_nxt = S_SO_SW1;
        end else begin
          ram_raddr = j_r[ADDR_W-1:0];
          state_nxt = S_SO_JCMP;
        end
      end
      S_SO_JCMP: begin
        if (bval_r > ram_rdata) begin
          bval_nxt = ram_rdata;
          best_nxt = j_r;
        end
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_SO_JRD;
      end
      S_SO_SW1: begin
        ram_we    = 1'b1;
        ram_waddr = best_r[ADDR_W-1:0];
        ram_wdata = ival_r;
        state_nxt = S_SO_SW2;
      end
      S_SO_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[ADDR_W-1:0];
        ram_wdata = bval_r;
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_SO_IRD;
      end
      S_SR_RD: begin
        if (lo_r < hx_r) begin
          ram_raddr = mid[ADDR_W-1:0];
          state_nxt = S_SR_CMP;
        end else begin
          stat_nxt  = ST_MISS;
          state_nxt = S_DONE;
        end
      end
      S_SR_CMP: begin
        if (ram_rdata > key_r) begin
          hx_nxt    = mid;
          state_nxt = S_SR_RD;
        end else if (ram_rdata < key_r) begin
          lo_nxt    = mid + CNT_W'(1);
          state_nxt = S_SR_RD;
        end else begin
          pos_nxt   = mid + CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_pos_nxt    = FIELD_W'(pos_r);
          out_cnt_nxt    = FIELD_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    lo_r         <= lo_nxt;
    hx_r         <= hx_nxt;
    best_r       <= best_nxt;
    key_r        <= key_nxt;
    ival_r       <= ival_nxt;
    bval_r       <= bval_nxt;
    stat_r       <= stat_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_cnt_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_WORDS))
    else $error("entry count above table size");

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r >= $past(cnt_r))
    else $error("entry count decreased");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat not launched from done state");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_LD_RD || state_r == S_SO_SW1 || state_r == S_SO_SW2))
    else $error("store written outside load or swap");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SR_CMP) |-> (lo_r < hx_r && hx_r <= cnt_r))
    else $error("binary search window out of range");
`endif

endmodule

@@ sim/tb_sorted_word_table_search.sv @@
// Self-checking bench for sorted_word_table_search: load, sort, search and unused opcode
// beats are checked against a behavioral copy of the word table kept in this file.
// Depends on swts_pkg and sorted_word_table_search.
module tb_sorted_word_table_search;
  import swts_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] count;
  } lookup_reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode = OP_LOAD;
  logic [KEY_W-1:0]     in_word_key = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [FIELD_W-1:0]   out_position;
  logic [FIELD_W-1:0]   out_entry_count;

  logic [KEY_W-1:0]     word_tbl [MAX_WORDS];
  int                   word_cnt = 0;
  lookup_reply_t        pending_replies [$];
  logic [KEY_W-1:0]     loaded_keys [$];

  int err_count = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_cyc = 0;
  int hold_cnt = 0;
  bit hold_req = 1'b0;
  int n_beats = 0, n_load = 0, n_dup = 0, n_full = 0;
  int n_sort = 0, n_search = 0, n_hit = 0, n_results = 0;

  sorted_word_table_search uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_word_key     (in_word_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  always #10 clk = ~clk;

  function automatic bit punct_byte(input logic [7:0] b);
    return b inside {CH_SPACE, CH_DQUOTE, CH_PERIOD, CH_APOS, CH_COMMA, CH_BANG, CH_QMARK};
  endfunction

  // Cut at the first zero byte, optionally drop punctuation, pack toward the top.
  function automatic logic [KEY_W-1:0] canon_word(input logic [KEY_W-1:0] key,
                                                  input bit drop_punct);
    logic [KEY_W-1:0] acc;
    int               kept;
    logic [7:0]       b;
    acc  = '0;
    kept = 0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = key[KEY_W-1-8*i -: 8];
      if (b == 8'h00) break;
      if (!(drop_punct && punct_byte(b))) begin
        acc[KEY_W-1-8*kept -: 8] = b;
        kept++;
      end
    end
    return acc;
  endfunction

  function automatic void selection_sort_table();
    int               best;
    logic [KEY_W-1:0] t;
    for (int i = 0; i < word_cnt; i++) begin
      best = i;
      for (int j = i + 1; j < word_cnt; j++)
        if (word_tbl[best] > word_tbl[j]) best = j;
      t              = word_tbl[best];
      word_tbl[best] = word_tbl[i];
      word_tbl[i]    = t;
    end
  endfunction

  function automatic int probe_table(input logic [KEY_W-1:0] target);
    int lo, hi, mid;
    lo = 0;
    hi = word_cnt - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (word_tbl[mid] > target) hi = mid - 1;
      else if (word_tbl[mid] < target) lo = mid + 1;
      else return mid;
    end
    return -1;
  endfunction

  function automatic void apply_table_op(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key);
    lookup_reply_t    r;
    logic [KEY_W-1:0] w;
    bit               dup;
    int               hit;
    r.status   = ST_OK;
    r.position = '0;
    n_beats++;
    case (op)
      OP_LOAD: begin
        n_load++;
        loaded_keys.push_back(key);
        w   = canon_word(key, 1'b1);
        dup = 1'b0;
        for (int j = 0; j < word_cnt; j++)
          if (word_tbl[j] == w) dup = 1'b1;
        if (dup) begin
          r.status = ST_DUP;
          n_dup++;
        end else if (word_cnt >= MAX_WORDS) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          word_tbl[word_cnt] = w;
          word_cnt++;
        end
      end
      OP_SORT: begin
        n_sort++;
        selection_sort_table();
      end
      OP_SEARCH: begin
        n_search++;
        hit = probe_table(canon_word(key, 1'b0));
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.position = FIELD_W'(hit + 1);
          n_hit++;
        end
      end
      default: ;
    endcase
    r.count = FIELD_W'(word_cnt);
    pending_replies.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_word_key <= key;
    do @(posedge clk); while (in_stall);
    apply_table_op(op, key);
  endtask

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 6))
      0: return CH_SPACE;
      1: return CH_DQUOTE;
      2: return CH_PERIOD;
      3: return CH_APOS;
      4: return CH_COMMA;
      5: return CH_BANG;
      default: return CH_QMARK;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] rand_word(input int min_len);
    logic [KEY_W-1:0] k;
    logic [7:0]       b;
    int               len, r;
    k   = '0;
    len = $urandom_range(min_len, KEY_BYTES);
    for (int i = 0; i < KEY_BYTES; i++) begin
      r = $urandom_range(0, 99);
      if (i < len) begin
        if (r < 65) b = 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 80) b = pick_punct();
        else b = 8'($urandom_range(1, 255));
      end else if (i == len) begin
        b = 8'h00;
      end else begin
        b = (r < 30) ? 8'($urandom_range(0, 255)) : 8'h00;
      end
      k[KEY_W-1-8*i -: 8] = b;
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_search_key();
    int r;
    r = $urandom_range(0, 99);
    if (word_cnt > 0 && r < 60) return word_tbl[$urandom_range(0, word_cnt - 1)];
    if (loaded_keys.size() > 0 && r < 80)
      return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
    return rand_word(0);
  endfunction

  function automatic logic [KEY_W-1:0] pick_load_key();
    if (loaded_keys.size() > 0 && $urandom_range(0, 99) < 20)
      return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
    return rand_word(0);
  endfunction

  task automatic test_empty_table();
    send_beat(OP_SEARCH, {"CAT", 40'h0});
    send_beat(OP_SORT, '0);
    send_beat(OP_UNUSED, '0);
  endtask

  task automatic test_load_cleanup();
    send_beat(OP_LOAD, {"C.A,T!", 16'h0});
    send_beat(OP_LOAD, {"DOG", 8'h00, "XYZ", 8'h00});
    send_beat(OP_LOAD, {" \"'.,!?", 8'h00});
    send_beat(OP_LOAD, '1);
    send_beat(OP_LOAD, '0);
    send_beat(OP_LOAD, {8'h00, "ABCDEFG"});
  endtask

  task automatic test_duplicate_words();
    send_beat(OP_LOAD, {"CAT", 40'h0});
    send_beat(OP_LOAD, {"CA T?", 24'h0});
  endtask

  task automatic test_unsorted_probe();
    send_beat(OP_SEARCH, {"CAT", 40'h0});
    send_beat(OP_SEARCH, '0);
  endtask

  task automatic test_sorted_lookup();
    send_beat(OP_SORT, '0);
    send_beat(OP_SEARCH, '0);
    send_beat(OP_SEARCH, '1);
    send_beat(OP_SEARCH, {"C.AT", 32'h0});
    send_beat(OP_SEARCH, {"DOG", 8'h00, "QRS", 8'h5A});
  endtask

  task automatic test_unused_opcode();
    send_beat(OP_UNUSED, '1);
  endtask

  task automatic test_random_traffic(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) send_beat(OP_LOAD, pick_load_key());
      else if (r < 86) send_beat(OP_SEARCH, pick_search_key());
      else if (r < 90) send_beat(OP_SORT, {$urandom, $urandom});
      else if (r < 93) send_beat(OP_UNUSED, {$urandom, $urandom});
      else send_beat(OP_SEARCH, {$urandom, $urandom});
    end
  endtask

  // Receiver holds off while the sender keeps offering; the block backs up.
  task automatic test_result_holdoff();
    hold_req   = 1'b1;
    burst_left = 30;
    for (int i = 0; i < 24; i++) send_beat(OP_SEARCH, pick_search_key());
  endtask

  task automatic test_fill_to_capacity();
    while (word_cnt < MAX_WORDS) send_beat(OP_LOAD, rand_word(5));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < 12; i++) send_beat(OP_LOAD, rand_word(6));
    for (int i = 0; i < 6; i++)
      send_beat(OP_LOAD, loaded_keys[$urandom_range(0, loaded_keys.size() - 1)]);
    for (int i = 0; i < 5; i++) send_beat(OP_SEARCH, pick_search_key());
    send_beat(OP_SORT, '0);
    send_beat(OP_SEARCH, word_tbl[0]);
    send_beat(OP_SEARCH, word_tbl[MAX_WORDS - 1]);
    for (int i = 0; i < 90; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat(OP_LOAD, rand_word(0));
      else send_beat(OP_SEARCH, pick_search_key());
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) begin
        hold_req = 1'b0;
        hold_cnt = 0;
      end
    end else begin
      stall_cyc++;
      case ((stall_cyc / 150) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ((stall_cyc % 5) < 2);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    lookup_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_replies.size() == 0) begin
        report_mismatch("result beat with nothing pending, status", out_status, -1);
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_position !== want.position)
          report_mismatch("position", out_position, want.position);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", out_entry_count, want.count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_load_cleanup();
    test_duplicate_words();
    test_unsorted_probe();
    test_sorted_lookup();
    test_unused_opcode();
    test_random_traffic(200);
    test_result_holdoff();
    test_random_traffic(220);
    test_fill_to_capacity();
    test_full_table();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d beats: %0d loads (%0d duplicate, %0d full), %0d sorts",
             n_beats, n_load, n_dup, n_full, n_sort);
    $display("%0d searches with %0d hits, %0d results checked, table size %0d",
             n_search, n_hit, n_results, word_cnt);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sorted_word_table_search.f @@
sv/swts_pkg.sv
sv/swts_ram.sv
sv/sorted_word_table_search.sv
sim/tb_sorted_word_table_search.sv
